/* rtl/core/srsw_pkg.sv */
// ----------------------------------------------------------------------------
// Selective-repeat send window package
// Shared widths, codes, payload structs and the controller/datapath interface.
// ----------------------------------------------------------------------------
package srsw_pkg;

   localparam int WINDOW_SLOTS = 8;
   localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
   localparam int COUNT_W      = $clog2(WINDOW_SLOTS + 1);
   localparam int SEQ_W        = 32;
   localparam int SLOT_FIELD_W = 3;
   localparam int WSIZE_W      = 4;
   localparam int RTO_W        = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RTO_TICKS   = 2'd1;

   localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RESET = 4'd8;
   localparam logic [RTO_W-1:0]   RTO_TICKS_RESET   = 16'd100;

   localparam logic [1:0] CMD_ACK   = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_OFFER = 2'd2;

   localparam logic [1:0] KIND_SEND   = 2'd0;
   localparam logic [1:0] KIND_RETX   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [SEQ_W-1:0] ack_seq;
   } req_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [SEQ_W-1:0]        seq_out;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [1:0]              status;
      logic                    window_empty;
      logic [SEQ_W-1:0]        base_seq;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic latch_req;
      logic ack_mark;
      logic slide;
      logic tick_start;
      logic scan_emit;
      logic scan_skip;
      logic offer_send;
      logic offer_refuse;
      logic emit_status;
   } dp_cmd_type;

   typedef struct packed {
      logic ack_in_window;
      logic slide_more;
      logic scan_more;
      logic scan_hit;
      logic window_open;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/core/srsw_ctrl.sv */
// ----------------------------------------------------------------------------
// Selective-repeat send window controller
// Sequences each command through the datapath and paces result transfers.
// ----------------------------------------------------------------------------
module srsw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_cmd,
   input  srsw_pkg::dp_status_type dp_status,
   output srsw_pkg::dp_cmd_type    dp_cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_ACK    = 7'b0000010,
      ST_SLIDE  = 7'b0000100,
      ST_TICK   = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_OFFER  = 7'b0100000,
      ST_STATUS = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.latch_req = 1'b1;
               case (req_cmd)
                  srsw_pkg::CMD_ACK:   state_in = ST_ACK;
                  srsw_pkg::CMD_TICK:  state_in = ST_TICK;
                  srsw_pkg::CMD_OFFER: state_in = ST_OFFER;
                  default:             state_in = ST_STATUS;
               endcase
            end
         end
         ST_ACK: begin
            dp_cmd.ack_mark = 1'b1;
            state_in = dp_status.ack_in_window ? ST_SLIDE : ST_STATUS;
         end
         ST_SLIDE: begin
            if (dp_status.slide_more) begin
               dp_cmd.slide = 1'b1;
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_TICK: begin
            dp_cmd.tick_start = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!dp_status.scan_more) begin
               state_in = ST_STATUS;
            end else if (!dp_status.scan_hit) begin
               dp_cmd.scan_skip = 1'b1;
            end else if (dp_status.out_free) begin
               dp_cmd.scan_emit = 1'b1;
            end
         end
         ST_OFFER: begin
            if (!dp_status.window_open) begin
               dp_cmd.offer_refuse = 1'b1;
               state_in = ST_STATUS;
            end else if (dp_status.out_free) begin
               dp_cmd.offer_send = 1'b1;
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (dp_status.out_free) begin
               dp_cmd.emit_status = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_load_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.scan_emit || dp_cmd.offer_send || dp_cmd.emit_status) |-> dp_status.out_free)
      else $error("result loaded while the output register was still occupied");

endmodule

/* rtl/core/srsw_dp.sv */
// ----------------------------------------------------------------------------
// Selective-repeat send window datapath
// Window pointers, time counter, per-slot acked flags and deadlines,
// configuration registers and the result output register.
// ----------------------------------------------------------------------------
module srsw_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [srsw_pkg::SEQ_W-1:0]         req_ack_seq,
   input  logic                               csr_valid,
   input  logic [srsw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [srsw_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output srsw_pkg::rsp_type                  rsp_data,
   input  srsw_pkg::dp_cmd_type               dp_cmd,
   output srsw_pkg::dp_status_type            dp_status
);

   logic [srsw_pkg::WSIZE_W-1:0]      window_size_ff;
   logic [srsw_pkg::RTO_W-1:0]        rto_ff;
   logic [srsw_pkg::SEQ_W-1:0]        base_ff, base_in;
   logic [srsw_pkg::SEQ_W-1:0]        next_seq_ff, next_seq_in;
   logic [srsw_pkg::SEQ_W-1:0]        now_ff, now_in;
   logic [srsw_pkg::SEQ_W-1:0]        ack_ff, ack_in;
   logic [1:0]                        code_ff, code_in;
   logic [srsw_pkg::COUNT_W-1:0]      scan_i_ff, scan_i_in;
   logic [srsw_pkg::WINDOW_SLOTS-1:0] acked_ff, acked_in;
   logic [srsw_pkg::SEQ_W-1:0] deadline_ff [srsw_pkg::WINDOW_SLOTS];
   logic [srsw_pkg::SEQ_W-1:0] deadline_in [srsw_pkg::WINDOW_SLOTS];
   logic              rsp_valid_ff, rsp_valid_in;
   srsw_pkg::rsp_type rsp_ff, rsp_in;

   logic [srsw_pkg::SEQ_W-1:0]  outstanding;
   logic [srsw_pkg::SEQ_W-1:0]  ack_offset;
   logic [srsw_pkg::SEQ_W-1:0]  scan_seq;
   logic [srsw_pkg::SEQ_W-1:0]  deadline_diff;
   logic [srsw_pkg::SEQ_W-1:0]  reload;
   logic [srsw_pkg::SEQ_W-1:0]  size_ext;
   logic [srsw_pkg::SEQ_W-1:0]  limit;
   logic [srsw_pkg::SLOT_W-1:0] scan_idx;
   logic [srsw_pkg::SLOT_W-1:0] next_idx;
   logic [srsw_pkg::SLOT_W-1:0] ack_idx;
   logic [srsw_pkg::SLOT_W-1:0] base_idx;
   logic                        out_free;

   always_comb begin
      outstanding   = next_seq_ff - base_ff;
      ack_offset    = ack_ff - base_ff;
      scan_seq      = base_ff + srsw_pkg::SEQ_W'(scan_i_ff);
      scan_idx      = scan_seq[srsw_pkg::SLOT_W-1:0];
      next_idx      = next_seq_ff[srsw_pkg::SLOT_W-1:0];
      ack_idx       = ack_ff[srsw_pkg::SLOT_W-1:0];
      base_idx      = base_ff[srsw_pkg::SLOT_W-1:0];
      deadline_diff = deadline_ff[scan_idx] - now_ff;
      reload        = now_ff + srsw_pkg::SEQ_W'(rto_ff);
      size_ext      = srsw_pkg::SEQ_W'(window_size_ff);
      limit         = (size_ext > srsw_pkg::SEQ_W'(srsw_pkg::WINDOW_SLOTS)) ?
                      srsw_pkg::SEQ_W'(srsw_pkg::WINDOW_SLOTS) : size_ext;
      out_free      = !rsp_valid_ff || rsp_ready;

      dp_status.ack_in_window = ack_offset < outstanding;
      dp_status.slide_more    = (base_ff != next_seq_ff) && acked_ff[base_idx];
      dp_status.scan_more     = (srsw_pkg::SEQ_W'(scan_i_ff) < outstanding) &&
                                (scan_i_ff < srsw_pkg::COUNT_W'(srsw_pkg::WINDOW_SLOTS));
      dp_status.scan_hit      = !acked_ff[scan_idx] && deadline_diff[srsw_pkg::SEQ_W-1];
      dp_status.window_open   = outstanding < limit;
      dp_status.out_free      = out_free;
   end

   always_comb begin
      base_in      = base_ff;
      next_seq_in  = next_seq_ff;
      now_in       = now_ff;
      ack_in       = ack_ff;
      code_in      = code_ff;
      scan_i_in    = scan_i_ff;
      acked_in     = acked_ff;
      deadline_in  = deadline_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (dp_cmd.latch_req) begin
         ack_in  = req_ack_seq;
         code_in = srsw_pkg::STATUS_OK;
      end
      if (dp_cmd.ack_mark) begin
         if (dp_status.ack_in_window) begin
            acked_in[ack_idx] = 1'b1;
         end else begin
            code_in = srsw_pkg::STATUS_IGNORED;
         end
      end
      if (dp_cmd.slide) begin
         base_in = base_ff + 1'b1;
      end
      if (dp_cmd.tick_start) begin
         now_in    = now_ff + 1'b1;
         scan_i_in = '0;
      end
      if (dp_cmd.scan_skip) begin
         scan_i_in = scan_i_ff + 1'b1;
      end
      if (dp_cmd.scan_emit) begin
         scan_i_in             = scan_i_ff + 1'b1;
         deadline_in[scan_idx] = reload;
         rsp_in                = '0;
         rsp_in.kind           = srsw_pkg::KIND_RETX;
         rsp_in.seq_out        = scan_seq;
         rsp_in.slot           = srsw_pkg::SLOT_FIELD_W'(scan_idx);
         rsp_valid_in          = 1'b1;
      end
      if (dp_cmd.offer_send) begin
         acked_in[next_idx]    = 1'b0;
         deadline_in[next_idx] = reload;
         next_seq_in           = next_seq_ff + 1'b1;
         rsp_in                = '0;
         rsp_in.kind           = srsw_pkg::KIND_SEND;
         rsp_in.seq_out        = next_seq_ff;
         rsp_in.slot           = srsw_pkg::SLOT_FIELD_W'(next_idx);
         rsp_valid_in          = 1'b1;
      end
      if (dp_cmd.offer_refuse) begin
         code_in = srsw_pkg::STATUS_FULL;
      end
      if (dp_cmd.emit_status) begin
         rsp_in              = '0;
         rsp_in.kind         = srsw_pkg::KIND_STATUS;
         rsp_in.status       = code_ff;
         rsp_in.window_empty = (next_seq_ff == base_ff);
         rsp_in.base_seq     = base_ff;
         rsp_in.last         = 1'b1;
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= srsw_pkg::WINDOW_SIZE_RESET;
         rto_ff         <= srsw_pkg::RTO_TICKS_RESET;
         base_ff        <= '0;
         next_seq_ff    <= '0;
         now_ff         <= '0;
         code_ff        <= srsw_pkg::STATUS_OK;
         scan_i_ff      <= '0;
         acked_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == srsw_pkg::REG_WINDOW_SIZE)) begin
            window_size_ff <= csr_data[srsw_pkg::WSIZE_W-1:0];
         end
         if (csr_valid && (csr_index == srsw_pkg::REG_RTO_TICKS)) begin
            rto_ff <= csr_data[srsw_pkg::RTO_W-1:0];
         end
         base_ff      <= base_in;
         next_seq_ff  <= next_seq_in;
         now_ff       <= now_in;
         code_ff      <= code_in;
         scan_i_ff    <= scan_i_in;
         acked_ff     <= acked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_ff      <= ack_in;
      rsp_ff      <= rsp_in;
      deadline_ff <= deadline_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_window_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding <= srsw_pkg::SEQ_W'(srsw_pkg::WINDOW_SLOTS))
      else $error("more packets outstanding than there are slots");

   a_last_marks_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.last == (rsp_ff.kind == srsw_pkg::KIND_STATUS)))
      else $error("last flag does not match the status result");

   a_slide_within_window: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.slide |=> (base_ff == $past(base_ff) + 1'b1) &&
                       (($past(next_seq_ff) - base_ff) < $past(outstanding)))
      else $error("window base slid past the next sequence number");

endmodule

/* rtl/core/selective_repeat_send_window.sv */
// ----------------------------------------------------------------------------
// Selective-repeat send window
// Send-window controller of a selective-repeat sender: assigns sequence
// numbers and slots, tracks acknowledgements and issues retransmissions.
//
//   Channel  Direction  Payload              Transfer
//   req      in         srsw_pkg::req_type   req_valid && req_ready
//   rsp      out        srsw_pkg::rsp_type   rsp_valid && rsp_ready
//   csr      in         index, 16-bit data   csr_valid && csr_ready
//
// One item is handled at a time. An offer sends a packet or is refused, an
// ACK marks its slot and slides the base over acked slots or is ignored, a
// tick retransmits each expired slot and an unused command only returns a
// status, the controller stepping one slot a cycle unless the output is busy.
// Each result waits in the output register while rsp_ready is low, which
// stalls the sequence. Reset is synchronous; csr writes are always taken.
// ----------------------------------------------------------------------------
module selective_repeat_send_window (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  srsw_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output srsw_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [srsw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srsw_pkg::CSR_DATA_W-1:0]  csr_data
);

   srsw_pkg::dp_cmd_type    dp_cmd;
   srsw_pkg::dp_status_type dp_status;

   assign csr_ready = 1'b1;

   srsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   srsw_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_ack_seq (req_data.ack_seq),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

endmodule
